// ----- design/rmns_pkg.sv -----
// ----------------------------------------------------------------------------
// rmns_pkg
// Shared types and constants of the stochastic Ricker map iterator.
// ----------------------------------------------------------------------------
`default_nettype none

package rmns_pkg;

   typedef struct packed {
      logic [15:0] noise;
      logic [31:0] growth_log;
      logic [15:0] noise_scale;
      logic        first_of_rep;
   } req_type;

   typedef struct packed {
      logic [31:0] pop_log;
      logic [15:0] sample_index;
      logic        last_of_rep;
   } rsp_type;

   typedef enum logic [1:0] {
      CSR_START_VALUE   = 2'd0,
      CSR_BURN_IN_STEPS = 2'd1,
      CSR_SERIES_LENGTH = 2'd2
   } csr_index_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic [31:0] START_VALUE_RESET   = 32'h0001_0000;
   localparam logic [15:0] BURN_IN_RESET       = 16'd50;
   localparam logic [15:0] SERIES_LENGTH_RESET = 16'd100;

   // log2(e) in Q2.30 and ln(2) in Q32
   localparam logic signed [31:0] LOG2E_Q30 = 32'sd1549082005;
   localparam logic [63:0]        LN2_Q32   = 64'd2977044472;

   // exp input below -16.0 gives zero
   localparam logic signed [31:0] EXP_LOW_LIMIT = -32'sd1048576;
   localparam logic signed [17:0] EXP_SAT_IP    = 18'sd15;
   localparam logic [31:0]        EXP_SAT_VALUE = 32'h7FFF_FFFF;

endpackage

`default_nettype wire

// ----- design/rmns_exp_rom.sv -----
// ----------------------------------------------------------------------------
// rmns_exp_rom
// Synchronous ROM of 2^(k/ENTRIES) in Q2.30, one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rmns_exp_rom
   import rmns_pkg::*;
#(
   parameter int ENTRIES = 1024,
   localparam int AddrW  = $clog2(ENTRIES)
) (
   input  wire logic             clock,
   input  wire logic             rd_en,
   input  wire logic [AddrW-1:0] rd_addr,
   output logic      [31:0]      rd_data
);

   typedef logic [31:0] table_type [ENTRIES];

   function automatic table_type build_table();
      table_type   t;
      logic [63:0] z;
      logic [63:0] sum;
      logic [63:0] term;
      for (int k = 0; k < ENTRIES; k++) begin
         z    = (64'(k) * LN2_Q32) / ENTRIES;
         sum  = 64'd1 << 32;
         term = 64'd1 << 32;
         for (int n = 1; n <= 12; n++) begin
            term = ((term * z) >> 32) / 64'(n);
            sum  = sum + term;
         end
         t[k] = 32'((sum + 64'd2) >> 2);
      end
      return t;
   endfunction

   localparam table_type ExpTable = build_table();

   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ExpTable[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/ricker_map_noise_driven_sim.sv -----
// ----------------------------------------------------------------------------
// ricker_map_noise_driven_sim
// Stochastic Ricker map on log population, Q16.16 state, table based exp.
// ----------------------------------------------------------------------------
// Each req transfer carries one noise sample with the replicate's growth_log
// and noise_scale; first_of_rep reloads the state from start_value and clears
// the step count. Steps inside the burn-in give no rsp transfer; the next
// series_length steps each give one, the last marked by last_of_rep.
// An accepted item is registered in the compute stage; its result then goes
// to the output register, from which the rsp transfer is made. The block takes
// no new item while the compute stage holds one. The loop through the state
// register (x*log2(e) multiply and exp ROM address on the req transfer, then
// ROM read data, shift and saturating sum in the compute stage) is the reason.
// The csr port writes start_value, burn_in_steps and series_length; write
// only while no item is in flight.
// Reset (synchronous) restores register defaults, sets the state to
// start_value and clears the step count and both valid flags.
// A waiting result does not block the next item; if a new result is due
// while the output is still stalled, the compute stage holds and req_stall
// stays high until the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module ricker_map_noise_driven_sim
   import rmns_pkg::*;
#(
   parameter int EXP_TABLE_ENTRIES = 1024,
   parameter int COUNT_BITS        = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_type                req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_type                     rsp_data,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IdxW   = $clog2(EXP_TABLE_ENTRIES);
   localparam int CntW   = COUNT_BITS + 1;
   localparam int CmpW   = ((CntW > 16) ? CntW : 16) + 1;
   localparam int IdxPrW = 16 + IdxW + 1;

   // configuration
   logic [31:0] start_value_ff;
   logic [15:0] burn_in_ff;
   logic [15:0] series_length_ff;

   // loop state
   logic [31:0]     x_ff;
   logic [CntW-1:0] cnt_ff;

   // compute stage
   logic        s1_valid_ff;
   logic [31:0] s1_x_ff;
   logic [31:0] s1_growth_ff;
   logic [24:0] s1_term_ff;
   logic        s1_zero_ff;
   logic        s1_sat_ff;
   logic [5:0]  s1_sh_ff;
   logic        s1_emit_ff;
   logic [15:0] s1_index_ff;
   logic        s1_last_ff;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic                     req_xfer;
   logic                     s1_done;
   logic [31:0]              x_sel;
   logic signed [63:0]       y_prod;
   logic signed [17:0]       ip;
   logic [15:0]              frac;
   logic [IdxPrW-1:0]        idx_prod;
   logic [IdxW-1:0]          rom_addr;
   logic [31:0]              rom_data;
   logic [32:0]              noise_prod;
   logic [6:0]               sh_full;
   logic [CntW-1:0]          s_sel;
   logic [CmpW-1:0]          s_ext;
   logic [CmpW-1:0]          k_val;
   logic                     emit;
   logic [31:0]              exp_val;
   logic signed [34:0]       sum;
   logic [31:0]              sum_sat;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = s1_valid_ff;
   assign s1_done   = s1_valid_ff && (!s1_emit_ff || !rsp_valid_ff || !rsp_stall);

   // on the req transfer: select state, scale by log2(e), address the ROM
   always_comb begin
      x_sel    = req_data.first_of_rep ? start_value_ff : x_ff;
      y_prod   = $signed(x_sel) * LOG2E_Q30;
      ip       = y_prod[63:46];
      frac     = y_prod[45:30];
      idx_prod = IdxPrW'(frac) * IdxPrW'(EXP_TABLE_ENTRIES);
      rom_addr = idx_prod[16 +: IdxW];
      sh_full  = 7'd14 - ip[6:0];
      noise_prod = {{17{req_data.noise[15]}}, req_data.noise}
                 * {17'd0, req_data.noise_scale};
      s_sel    = req_data.first_of_rep ? '0 : cnt_ff;
      s_ext    = CmpW'(s_sel);
      k_val    = s_ext - CmpW'(burn_in_ff);
      emit     = (s_sel != '1) && (s_ext >= CmpW'(burn_in_ff))
              && (k_val < CmpW'(series_length_ff));
   end

   rmns_exp_rom #(
      .ENTRIES (EXP_TABLE_ENTRIES)
   ) u_exp_rom (
      .clock   (clock),
      .rd_en   (req_xfer),
      .rd_addr (rom_addr),
      .rd_data (rom_data)
   );

   // compute stage: finish exp, saturating sum
   always_comb begin
      priority if (s1_zero_ff) begin
         exp_val = '0;
      end else if (s1_sat_ff) begin
         exp_val = EXP_SAT_VALUE;
      end else begin
         exp_val = rom_data >> s1_sh_ff;
      end
      sum = $signed({{3{s1_x_ff[31]}}, s1_x_ff})
          + $signed({{3{s1_growth_ff[31]}}, s1_growth_ff})
          - $signed({3'd0, exp_val})
          + $signed({{10{s1_term_ff[24]}}, s1_term_ff});
      priority if (sum[34] && (sum[33:31] != 3'b111)) begin
         sum_sat = 32'h8000_0000;
      end else if (!sum[34] && (sum[33:31] != 3'b000)) begin
         sum_sat = 32'h7FFF_FFFF;
      end else begin
         sum_sat = sum[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_value_ff   <= START_VALUE_RESET;
         burn_in_ff       <= BURN_IN_RESET;
         series_length_ff <= SERIES_LENGTH_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_VALUE:   start_value_ff   <= csr_wdata;
            CSR_BURN_IN_STEPS: burn_in_ff       <= csr_wdata[15:0];
            CSR_SERIES_LENGTH: series_length_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= START_VALUE_RESET;
         cnt_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_xfer) begin
            s1_valid_ff <= 1'b1;
            cnt_ff      <= (s_sel != '1) ? s_sel + 1'b1 : s_sel;
         end else if (s1_done) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_done) begin
            x_ff <= sum_sat;
         end
         if (s1_done && s1_emit_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_x_ff      <= x_sel;
         s1_growth_ff <= req_data.growth_log;
         s1_term_ff   <= noise_prod[32:8];
         s1_zero_ff   <= $signed(x_sel) < EXP_LOW_LIMIT;
         s1_sat_ff    <= ip >= EXP_SAT_IP;
         s1_sh_ff     <= sh_full[5:0];
         s1_emit_ff   <= emit;
         s1_index_ff  <= k_val[15:0];
         s1_last_ff   <= (k_val + 1'b1) == CmpW'(series_length_ff);
      end
      if (s1_done && s1_emit_ff) begin
         rsp_data_ff.pop_log      <= sum_sat;
         rsp_data_ff.sample_index <= s1_index_ff;
         rsp_data_ff.last_of_rep  <= s1_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_back_to_back_req : assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_xfer)
      else $error("req transfer taken while the compute stage was busy");

   a_last_matches_length : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last_of_rep)
         |-> (17'(rsp_data.sample_index) + 17'd1) == 17'(series_length_ff))
      else $error("last_of_rep on a result that is not the final one");

   a_index_in_series : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sample_index < series_length_ff)
      else $error("sample_index beyond series_length");

endmodule

`default_nettype wire
